/* design/gpx_pkg.sv */
// shared types and constants for the grid path xor counter
`default_nettype none
package gpx_pkg;

  localparam int unsigned XOR_STATES = 16;
  localparam int unsigned XOR_W      = 4;
  localparam int unsigned COUNT_W    = 30;
  localparam int unsigned CFG_W      = 9;
  localparam int unsigned REG_IDX_W  = 1;

  localparam logic [COUNT_W-1:0] PATH_MOD = 30'd1000000007;

  localparam logic [REG_IDX_W-1:0] REG_TARGET_XOR   = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_GRID_COLUMNS = 1'd1;

  typedef logic [XOR_STATES-1:0][COUNT_W-1:0] counts_t;

endpackage
`default_nettype wire

/* design/grid_path_xor_count.sv */
// grid path xor counter: row store memory, per-cell update and result register
//
//   channel   direction  fields                    handshake
//   in        sink       cell_value_i, last_cell_i in_valid_i / in_stall_o
//   out       source     path_count_o              out_valid_o / out_stall_i
//   cfg       sink       cfg_index_i, cfg_data_i   cfg_we_i
//
// one cell per cycle while in_stall_o is low; a cell's counts are written back from the stage 1 registers
// a last cell's result passes through the stage 1 registers into the result register
// the row store is read at request and written from the stage 1 registers, with forwarding
// from the cell in flight when both fall on the same column
// in_stall_o rises only while a last cell waits behind a stalled, full result register
// reset clears control state; the row store has no clear and needs none
`default_nettype none
module grid_path_xor_count
  import gpx_pkg::*;
#(
  parameter int unsigned MAX_COLUMNS = 256
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    cfg_we_i,
  input  wire  [REG_IDX_W-1:0]   cfg_index_i,
  input  wire  [CFG_W-1:0]       cfg_data_i,
  input  wire                    in_valid_i,
  output logic                   in_stall_o,
  input  wire  [XOR_W-1:0]       cell_value_i,
  input  wire                    last_cell_i,
  output logic                   out_valid_o,
  input  wire                    out_stall_i,
  output logic [COUNT_W-1:0]     path_count_o
);

  localparam int unsigned AW  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int unsigned CW  = $clog2(MAX_COLUMNS + 1);
  localparam int unsigned NW  = (CW > CFG_W) ? CW : CFG_W;
  localparam logic [NW-1:0] MAX_N = NW'(MAX_COLUMNS);

  // config registers
  logic [XOR_W-1:0] target_q;
  logic [CFG_W-1:0] columns_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q  <= '0;
      columns_q <= CFG_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_TARGET_XOR:   target_q  <= cfg_data_i[XOR_W-1:0];
        REG_GRID_COLUMNS: columns_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [NW-1:0] ncol;
  always_comb begin
    ncol = NW'(columns_q);
    if (ncol == '0) ncol = NW'(1);
    if (ncol > MAX_N) ncol = MAX_N;
  end

  // request side: column tracking
  logic [CW-1:0] col_q, col_d;
  logic          first_q, first_d;
  logic [CW-1:0] pos_eff;
  logic          first_eff;
  logic [CW-1:0] pos_inc;
  logic          in_acc;

  // stage 1 registers
  logic             s1_valid_q;
  logic             s1_last_q;
  logic             s1_first_q;
  logic             s1_fwd_q;
  logic [AW-1:0]    s1_pos_q;
  logic [XOR_W-1:0] s1_v_q;
  logic             s1_block;
  logic             s1_done;

  assign s1_block   = s1_valid_q && s1_last_q && out_valid_o && out_stall_i;
  assign s1_done    = s1_valid_q && !s1_block;
  assign in_stall_o = s1_block;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    if (NW'(col_q) >= ncol) begin
      pos_eff   = '0;
      first_eff = 1'b0;
    end else begin
      pos_eff   = col_q;
      first_eff = first_q;
    end
    pos_inc = pos_eff + CW'(1);
    col_d   = col_q;
    first_d = first_q;
    if (in_acc) begin
      if (last_cell_i) begin
        col_d   = '0;
        first_d = 1'b1;
      end else if (NW'(pos_inc) >= ncol) begin
        col_d   = '0;
        first_d = 1'b0;
      end else begin
        col_d   = pos_inc;
        first_d = first_eff;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      first_q    <= 1'b1;
      s1_valid_q <= 1'b0;
    end else begin
      col_q   <= col_d;
      first_q <= first_d;
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_done) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_last_q  <= last_cell_i;
      s1_first_q <= first_eff;
      s1_pos_q   <= pos_eff[AW-1:0];
      s1_v_q     <= cell_value_i;
      s1_fwd_q   <= s1_done && (s1_pos_q == pos_eff[AW-1:0]);
    end
  end

  // row store
  counts_t row_mem [MAX_COLUMNS];
  counts_t rd_q;
  counts_t left_q;
  counts_t fresh;

  always_ff @(posedge clk_i) begin
    if (s1_done) begin
      row_mem[s1_pos_q] <= fresh;
    end
    if (in_acc) begin
      rd_q <= row_mem[pos_eff[AW-1:0]];
    end
  end

  // per-cell update, one lane per xor value
  always_comb begin
    logic [XOR_W-1:0]   src;
    logic [COUNT_W-1:0] lft;
    logic [COUNT_W-1:0] up;
    logic [COUNT_W:0]   sum;
    counts_t            up_row;
    up_row = s1_fwd_q ? left_q : rd_q;
    for (int x = 0; x < XOR_STATES; x++) begin
      src = XOR_W'(x) ^ s1_v_q;
      lft = (s1_pos_q == '0) ? '0 : left_q[src];
      up  = s1_first_q ? '0 : up_row[src];
      sum = {1'b0, lft} + {1'b0, up};
      if (sum >= {1'b0, PATH_MOD}) begin
        sum = sum - {1'b0, PATH_MOD};
      end
      if (s1_first_q && (s1_pos_q == '0)) begin
        sum = (XOR_W'(x) == s1_v_q) ? (COUNT_W + 1)'(1) : '0;
      end
      fresh[x] = sum[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_done) begin
      left_q <= fresh;
    end
  end

  // result register
  logic               out_valid_q;
  logic [COUNT_W-1:0] path_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_done && s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_done && s1_last_q) begin
      path_count_q <= fresh[target_q];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign path_count_o = path_count_q;

  a_stall_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && s1_last_q))
    else $error("stall without a pending last cell");

  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> s1_valid_q)
    else $error("accepted cell missing from stage 1");

  a_last_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_done && s1_last_q) |=> out_valid_o)
    else $error("last cell produced no result");

  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && last_cell_i) |=> (col_q == '0 && first_q))
    else $error("grid did not restart after last cell");

  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !last_cell_i) |=> (NW'(col_q) < ncol || $past(NW'(col_q)) >= ncol
      || $past(cfg_we_i)))
    else $error("column position beyond row length");

endmodule
`default_nettype wire

/* bench/tb.sv */
// testbench for the grid path xor counter: directed and random grids against a predictor
`timescale 1ns / 1ps
module tb
  import gpx_pkg::*;
();

  localparam int unsigned MAX_COLS = 256;

  logic                 clk_i        = 1'b0;
  logic                 rst_ni       = 1'b0;
  logic                 cfg_we_i     = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index_i  = REG_TARGET_XOR;
  logic [CFG_W-1:0]     cfg_data_i   = '0;
  logic                 in_valid_i   = 1'b0;
  logic                 in_stall_o;
  logic [XOR_W-1:0]     cell_value_i = '0;
  logic                 last_cell_i  = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i  = 1'b0;
  logic [COUNT_W-1:0]   path_count_o;

  grid_path_xor_count #(.MAX_COLUMNS(MAX_COLS)) i_dut (.*);

  always #4 clk_i = ~clk_i;

  // predictor state
  logic [COUNT_W-1:0] row_model [MAX_COLS][XOR_STATES];
  logic [COUNT_W-1:0] left_model [XOR_STATES];
  int unsigned        col_model;
  bit                 top_row_model;
  logic [XOR_W-1:0]   target_model;
  logic [CFG_W-1:0]   columns_model;

  logic [COUNT_W-1:0] expected_counts [$];
  int unsigned        mismatches = 0;
  bit                 idle_on    = 1'b1;
  int unsigned        hold_left  = 0;
  int unsigned        stall_left = 0;

  function automatic int unsigned active_cols();
    if (columns_model == 0) return 1;
    if (columns_model > MAX_COLS) return MAX_COLS;
    return columns_model;
  endfunction

  function automatic void restart_model();
    for (int x = 0; x < XOR_STATES; x++) left_model[x] = '0;
    col_model = 0;
    top_row_model = 1'b1;
  endfunction

  function automatic void flag_error(string what, logic [COUNT_W-1:0] want,
                                     logic [COUNT_W-1:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("tb: mismatch on %s at %0t: expected %0d, got %0d", what, $realtime, want, got);
  endfunction

  // per-cell update of the 16 xor counts, queues the count on the last cell
  function automatic void step_path_counts(logic [XOR_W-1:0] value, logic last);
    logic [COUNT_W-1:0] fresh [XOR_STATES];
    logic [COUNT_W:0]   sum;
    logic [COUNT_W-1:0] left_c;
    logic [COUNT_W-1:0] up_c;
    logic [XOR_W-1:0]   src;
    int unsigned        ncol;
    ncol = active_cols();
    if (col_model >= ncol) begin
      col_model = 0;
      top_row_model = 1'b0;
    end
    for (int x = 0; x < XOR_STATES; x++) begin
      src = XOR_W'(x) ^ value;
      left_c = (col_model == 0) ? '0 : left_model[src];
      up_c = top_row_model ? '0 : row_model[col_model][src];
      sum = {1'b0, left_c} + {1'b0, up_c};
      if (sum >= {1'b0, PATH_MOD}) sum = sum - {1'b0, PATH_MOD};
      if (top_row_model && col_model == 0)
        sum = (XOR_W'(x) == value) ? (COUNT_W + 1)'(1) : '0;
      fresh[x] = sum[COUNT_W-1:0];
    end
    for (int x = 0; x < XOR_STATES; x++) begin
      left_model[x] = fresh[x];
      row_model[col_model][x] = fresh[x];
    end
    if (last) begin
      expected_counts.push_back(fresh[target_model]);
      restart_model();
    end else begin
      col_model++;
      if (col_model >= ncol) begin
        col_model = 0;
        top_row_model = 1'b0;
      end
    end
  endfunction

  // result side: check, then decide the stall for the next cycle
  always @(posedge clk_i) begin : result_side
    logic [COUNT_W-1:0] want;
    if (out_valid_o === 1'b1 && !out_stall_i) begin
      if (expected_counts.size() == 0) begin
        flag_error("unexpected result", '0, path_count_o);
      end else begin
        want = expected_counts.pop_front();
        if (path_count_o !== want) flag_error("path_count", want, path_count_o);
      end
      if (idle_on) stall_left = $urandom_range(0, 9);
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic send_cell(input logic [XOR_W-1:0] value, input logic last);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 9) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cell_value_i <= value;
    last_cell_i <= last;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    step_path_counts(value, last);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_counts.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] index, input logic [CFG_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= data;
    @(posedge clk_i);
    if (index == REG_TARGET_XOR) target_model = data[XOR_W-1:0];
    else columns_model = data;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_grid(input int unsigned cells, input bit sparse);
    logic [XOR_W-1:0] value;
    for (int unsigned i = 0; i < cells; i++) begin
      value = XOR_W'($urandom_range(0, 15));
      if (sparse && $urandom_range(0, 15) != 0) value = '0;
      send_cell(value, i == cells - 1);
    end
  endtask

  task automatic test_reset_defaults();
    idle_on = 1'b1;
    send_cell(4'd0, 1'b1);
    send_cell(4'd15, 1'b1);
    send_cell(4'd3, 1'b0);
    send_cell(4'd12, 1'b0);
    send_cell(4'd15, 1'b1);
  endtask

  task automatic test_column_clamp();
    wait_idle();
    write_reg(REG_GRID_COLUMNS, 9'd0);
    write_reg(REG_TARGET_XOR, 9'h1ff);
    send_cell(4'd15, 1'b0);
    send_cell(4'd0, 1'b1);
    wait_idle();
    write_reg(REG_GRID_COLUMNS, 9'd511);
    send_cell(4'd7, 1'b0);
    send_cell(4'd8, 1'b1);
  endtask

  task automatic test_small_grid();
    wait_idle();
    write_reg(REG_GRID_COLUMNS, 9'd2);
    write_reg(REG_TARGET_XOR, 9'd11);
    send_cell(4'd1, 1'b0);
    send_cell(4'd2, 1'b0);
    send_cell(4'd4, 1'b0);
    send_cell(4'd8, 1'b1);
  endtask

  // shrink the row width between grids, then grow it in the middle of a grid
  task automatic test_column_change();
    wait_idle();
    write_reg(REG_GRID_COLUMNS, 9'd4);
    write_reg(REG_TARGET_XOR, CFG_W'($urandom_range(0, 15)));
    run_grid(6, 1'b0);
    in_valid_i <= 1'b0;
    wait_idle();
    write_reg(REG_GRID_COLUMNS, 9'd2);
    send_cell(XOR_W'($urandom_range(0, 15)), 1'b0);
    send_cell(XOR_W'($urandom_range(0, 15)), 1'b0);
    wait_idle();
    write_reg(REG_GRID_COLUMNS, 9'd4);
    run_grid(4, 1'b0);
  endtask

  task automatic test_backpressure();
    wait_idle();
    write_reg(REG_GRID_COLUMNS, 9'd1);
    idle_on = 1'b0;
    hold_left = 150;
    repeat (16) send_cell(XOR_W'($urandom_range(0, 15)), 1'b1);
    wait_idle();
  endtask

  task automatic test_random();
    int unsigned      sent;
    int unsigned      grids;
    int unsigned      rows;
    int unsigned      cells;
    logic [CFG_W-1:0] col_reg;
    logic [CFG_W-1:0] target_reg;
    bit               sparse;
    sent = 0;
    grids = 0;
    while (sent < 900) begin
      wait_idle();
      idle_on = $urandom_range(0, 3) != 0;
      sparse = 1'b0;
      target_reg = CFG_W'($urandom_range(0, 511));
      if (grids == 0) begin
        // mostly zero cells so the counts wrap the modulus
        col_reg = 9'd18;
        rows = 18;
        sparse = 1'b1;
        target_reg = CFG_W'($urandom_range(0, 31) << XOR_W);
      end else if (grids == 1) begin
        col_reg = 9'd256;
        rows = 2;
      end else if ($urandom_range(0, 15) == 0) begin
        col_reg = $urandom_range(0, 1) ? 9'd0 : CFG_W'($urandom_range(257, 511));
        rows = $urandom_range(1, 3);
      end else begin
        col_reg = CFG_W'($urandom_range(1, 8));
        rows = $urandom_range(1, 6);
      end
      write_reg(REG_TARGET_XOR, target_reg);
      write_reg(REG_GRID_COLUMNS, col_reg);
      cells = active_cols() * rows;
      if (grids > 1 && active_cols() == MAX_COLS) cells = $urandom_range(1, 24);
      else if (grids > 1 && $urandom_range(0, 5) == 0) cells = $urandom_range(1, cells);
      run_grid(cells, sparse);
      sent += cells;
      grids++;
    end
  endtask

  initial begin
    target_model = '0;
    columns_model = 9'd1;
    restart_model();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_column_clamp();
    test_small_grid();
    test_column_change();
    test_backpressure();
    test_random();
    wait_idle();
    repeat (16) @(posedge clk_i);
    if (mismatches == 0 && expected_counts.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: done, errors");
    $finish;
  end

endmodule
